@@ rtl/core/akf_pkg.sv @@
// shared widths, step codes, command and status types and saturation helpers
package akf_pkg;

	localparam int ANGLE_W   = 32;
	localparam int COV_W     = 48;
	localparam int DT_W      = 20;
	localparam int WIDE_W    = 52;
	localparam int OPND_W    = 49;
	localparam int MAG_W     = 48;
	localparam int PROD_W    = 96;
	localparam int DIV_W     = 78;
	localparam int DIV_CNT_W = 7;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_Q_ANGLE = 2'd0;
	localparam logic [IDX_W-1:0] REG_Q_BIAS  = 2'd1;
	localparam logic [IDX_W-1:0] REG_R_MEAS  = 2'd2;

	localparam logic [ANGLE_W-1:0] Q_ANGLE_RST = 32'd1073742;
	localparam logic [ANGLE_W-1:0] Q_BIAS_RST  = 32'd3221225;
	localparam logic [ANGLE_W-1:0] R_MEAS_RST  = 32'd32212255;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RATE,
		ST_ANG,
		ST_DTP11,
		ST_P00,
		ST_P11,
		ST_DIV0,
		ST_DIV1,
		ST_K0Y,
		ST_K1Y,
		ST_K0P00,
		ST_K0P01,
		ST_K1P00,
		ST_K1P01
	} step_t;

	typedef struct packed {
		logic  capture;
		logic  mul_start;
		logic  div_start;
		logic  commit;
		logic  out_load;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} sts_t;

	function automatic logic step_uses_mul(input step_t st);
		logic r;
		unique case (st)
			ST_ANG, ST_DTP11, ST_P00, ST_P11, ST_K0Y, ST_K1Y,
			ST_K0P00, ST_K0P01, ST_K1P00, ST_K1P01: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic step_uses_div(input step_t st);
		return (st == ST_DIV0) || (st == ST_DIV1);
	endfunction

	function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [ANGLE_W-1:0] r;
		if ((&v[WIDE_W-1:ANGLE_W-1]) || !(|v[WIDE_W-1:ANGLE_W-1])) begin
			r = v[ANGLE_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(ANGLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(ANGLE_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [COV_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
		logic signed [COV_W-1:0] r;
		if ((&v[WIDE_W-1:COV_W-1]) || !(|v[WIDE_W-1:COV_W-1])) begin
			r = v[COV_W-1:0];
		end else if (v[WIDE_W-1]) begin
			r = {1'b1, {(COV_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COV_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

@@ rtl/core/akf_mul.sv @@
// sequential signed multiplier, 16 bits of one operand per cycle, rounding and saturation
module akf_mul import akf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [OPND_W-1:0] a,
	input  logic signed [OPND_W-1:0] b,
	input  logic                     shift30,
	input  logic                     wide48,
	output logic                     done,
	output logic signed [COV_W-1:0]  res
);

	logic [MAG_W-1:0]  ma_q, mb_q;
	logic              neg_q, sh_q, wd_q;
	logic [PROD_W-1:0] acc_q;
	logic [1:0]        cnt_q;
	logic              busy_q, rnd_q, done_q;
	logic signed [COV_W-1:0] res_q;

	logic [OPND_W-1:0] abs_a, abs_b;
	logic [15:0]       digit;
	logic [63:0]       prod;
	logic [PROD_W:0]   sum, quo, lim, mag;
	logic [COV_W-1:0]  mag48;

	assign abs_a = a[OPND_W-1] ? OPND_W'(-a) : OPND_W'(a);
	assign abs_b = b[OPND_W-1] ? OPND_W'(-b) : OPND_W'(b);

	always_comb begin
		unique case (cnt_q)
			2'd0:    digit = mb_q[47:32];
			2'd1:    digit = mb_q[31:16];
			default: digit = mb_q[15:0];
		endcase
	end

	assign prod  = ma_q * digit;
	assign sum   = {1'b0, acc_q} + (sh_q ? ((PROD_W+1)'(1) << 29) : ((PROD_W+1)'(1) << 19));
	assign quo   = sh_q ? (sum >> 30) : (sum >> 20);
	assign lim   = (wd_q ? ((PROD_W+1)'(1) << 47) : ((PROD_W+1)'(1) << 31))
		- (PROD_W+1)'(!neg_q);
	assign mag   = (quo > lim) ? lim : quo;
	assign mag48 = mag[COV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= rnd_q && !start && !busy_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 2'd1;
				end
			end else if (rnd_q) begin
				rnd_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= abs_a[MAG_W-1:0];
			mb_q  <= abs_b[MAG_W-1:0];
			neg_q <= a[OPND_W-1] ^ b[OPND_W-1];
			sh_q  <= shift30;
			wd_q  <= wide48;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PROD_W-17:0], 16'b0} + PROD_W'(prod);
		end
		if (rnd_q) begin
			res_q <= neg_q ? COV_W'(-mag48) : COV_W'(mag48);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/core/akf_div.sv @@
// restoring divider for the gains, one quotient bit per cycle
module akf_div import akf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [COV_W-1:0] num,
	input  logic signed [COV_W-1:0] den,
	output logic                    done,
	output logic signed [COV_W-1:0] res
);

	logic [DIV_W-1:0]     dvd_q, quo_q;
	logic [MAG_W-1:0]     ud_q, rem_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, fin_q, done_q;
	logic signed [COV_W-1:0] res_q;

	logic [MAG_W-1:0] abs_n, abs_d;
	logic [MAG_W:0]   r2, diff;
	logic             ge, over;
	logic [COV_W-1:0] q48;

	assign abs_n = num[COV_W-1] ? MAG_W'(-num) : MAG_W'(num);
	assign abs_d = den[COV_W-1] ? MAG_W'(-den) : MAG_W'(den);
	assign r2    = {rem_q, dvd_q[DIV_W-1]};
	assign diff  = r2 - {1'b0, ud_q};
	assign ge    = r2 >= {1'b0, ud_q};
	assign over  = |quo_q[DIV_W-1:COV_W-1];
	assign q48   = {1'b0, quo_q[COV_W-2:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q && !start && !busy_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end else begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {abs_n, 30'b0};
			ud_q  <= abs_d;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= num[COV_W-1] ^ den[COV_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[MAG_W-1:0] : r2[MAG_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
		if (fin_q) begin
			if (over) begin
				res_q <= neg_q ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
			end else begin
				res_q <= neg_q ? COV_W'(-q48) : COV_W'(q48);
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/core/akf_datapath.sv @@
// filter state, configuration registers, operand selection and step updates
module akf_datapath import akf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [ANGLE_W-1:0]        cfg_data,
	input  logic signed [ANGLE_W-1:0] measured_angle,
	input  logic signed [ANGLE_W-1:0] measured_rate,
	input  logic [DT_W-1:0]           time_step,
	output logic signed [ANGLE_W-1:0] filtered_angle,
	output logic signed [ANGLE_W-1:0] corrected_rate
);

	logic [ANGLE_W-1:0]        qa_q, qb_q, rm_q;
	logic signed [ANGLE_W-1:0] z_q, w_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [ANGLE_W-1:0] angle_q, bias_q, rate_q;
	logic signed [COV_W-1:0]   p0_q, p1_q, p2_q, p3_q;
	logic signed [COV_W-1:0]   k0_q, k1_q, inner_q, p00t_q, p01t_q, s_q;
	logic signed [ANGLE_W:0]   y_q;
	logic signed [ANGLE_W-1:0] filt_q, corr_q;

	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic                     mul_sh, mul_wd, mul_done, div_done;
	logic signed [COV_W-1:0]  mr, dr, div_num;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = 1'b0;
		mul_wd = 1'b1;
		unique case (cmd.step)
			ST_ANG: begin
				mul_a  = OPND_W'(signed'({1'b0, dt_q}));
				mul_b  = OPND_W'(rate_q);
				mul_wd = 1'b0;
			end
			ST_DTP11: begin
				mul_a = OPND_W'(signed'({1'b0, dt_q}));
				mul_b = OPND_W'(p3_q);
			end
			ST_P00: begin
				mul_a = OPND_W'(signed'({1'b0, dt_q}));
				mul_b = OPND_W'(inner_q);
			end
			ST_P11: begin
				mul_a = OPND_W'(signed'({1'b0, qb_q}));
				mul_b = OPND_W'(signed'({1'b0, dt_q}));
			end
			ST_K0Y: begin
				mul_a  = OPND_W'(k0_q);
				mul_b  = OPND_W'(y_q);
				mul_sh = 1'b1;
			end
			ST_K1Y: begin
				mul_a  = OPND_W'(k1_q);
				mul_b  = OPND_W'(y_q);
				mul_sh = 1'b1;
			end
			ST_K0P00: begin
				mul_a  = OPND_W'(k0_q);
				mul_b  = OPND_W'(p00t_q);
				mul_sh = 1'b1;
			end
			ST_K0P01: begin
				mul_a  = OPND_W'(k0_q);
				mul_b  = OPND_W'(p01t_q);
				mul_sh = 1'b1;
			end
			ST_K1P00: begin
				mul_a  = OPND_W'(k1_q);
				mul_b  = OPND_W'(p00t_q);
				mul_sh = 1'b1;
			end
			ST_K1P01: begin
				mul_a  = OPND_W'(k1_q);
				mul_b  = OPND_W'(p01t_q);
				mul_sh = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign div_num = (cmd.step == ST_DIV1) ? p2_q : p0_q;

	akf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.shift30 (mul_sh),
		.wide48  (mul_wd),
		.done    (mul_done),
		.res     (mr)
	);

	akf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.res    (dr)
	);

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q    <= Q_ANGLE_RST;
			qb_q    <= Q_BIAS_RST;
			rm_q    <= R_MEAS_RST;
			angle_q <= '0;
			bias_q  <= '0;
			rate_q  <= '0;
			p0_q    <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
			p3_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_Q_ANGLE: qa_q <= cfg_data;
					REG_Q_BIAS:  qb_q <= cfg_data;
					REG_R_MEAS:  rm_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.commit) begin
				unique case (cmd.step)
					ST_LOAD: angle_q <= z_q;
					ST_RATE: rate_q <= sat32(WIDE_W'(w_q) - WIDE_W'(bias_q));
					ST_ANG:  angle_q <= sat32(WIDE_W'(angle_q) + WIDE_W'(mr));
					ST_DTP11: begin
						p1_q <= sat48(WIDE_W'(p1_q) - WIDE_W'(mr));
						p2_q <= sat48(WIDE_W'(p2_q) - WIDE_W'(mr));
					end
					ST_P00:   p0_q <= sat48(WIDE_W'(p0_q) + WIDE_W'(mr));
					ST_P11:   p3_q <= sat48(WIDE_W'(p3_q) + WIDE_W'(mr));
					ST_K0Y:   angle_q <= sat32(WIDE_W'(angle_q) + WIDE_W'(mr));
					ST_K1Y:   bias_q <= sat32(WIDE_W'(bias_q) + WIDE_W'(mr));
					ST_K0P00: p0_q <= sat48(WIDE_W'(p0_q) - WIDE_W'(mr));
					ST_K0P01: p1_q <= sat48(WIDE_W'(p1_q) - WIDE_W'(mr));
					ST_K1P00: p2_q <= sat48(WIDE_W'(p2_q) - WIDE_W'(mr));
					ST_K1P01: p3_q <= sat48(WIDE_W'(p3_q) - WIDE_W'(mr));
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			z_q  <= measured_angle;
			w_q  <= measured_rate;
			dt_q <= time_step;
		end
		if (cmd.commit) begin
			unique case (cmd.step)
				ST_DTP11: begin
					inner_q <= sat48(WIDE_W'(mr) - WIDE_W'(p1_q) - WIDE_W'(p2_q)
						+ WIDE_W'(signed'({1'b0, qa_q})));
				end
				ST_P11: begin
					p00t_q <= p0_q;
					p01t_q <= p1_q;
					s_q    <= sat48(WIDE_W'(p0_q) + WIDE_W'(signed'({1'b0, rm_q})));
					y_q    <= (ANGLE_W+1)'(z_q) - (ANGLE_W+1)'(angle_q);
				end
				ST_DIV0: k0_q <= (s_q == '0) ? '0 : dr;
				ST_DIV1: k1_q <= (s_q == '0) ? '0 : dr;
				default: begin
				end
			endcase
		end
		if (cmd.out_load) begin
			filt_q <= angle_q;
			corr_q <= rate_q;
		end
	end

	assign filtered_angle = filt_q;
	assign corrected_rate = corr_q;

endmodule

@@ rtl/core/akf_ctrl.sv @@
// sequencer that walks the update steps and runs the request handshakes
module akf_ctrl import akf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_OUT
	} state_t;

	state_t state_q;
	step_t  step_q;
	logic   out_valid_q;
	logic   uses_unit, last_step, unit_done;

	assign uses_unit = step_uses_mul(step_q) || step_uses_div(step_q);
	assign last_step = (step_q == ST_LOAD) || (step_q == ST_K1P01);
	assign unit_done = sts.mul_done || sts.div_done;

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.capture   = in_valid && in_ready;
	assign cmd.step      = step_q;
	assign cmd.mul_start = (state_q == S_EXEC) && step_uses_mul(step_q);
	assign cmd.div_start = (state_q == S_EXEC) && step_uses_div(step_q);
	assign cmd.commit    = ((state_q == S_EXEC) && !uses_unit)
		|| ((state_q == S_WAIT) && unit_done);
	assign cmd.out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						step_q  <= operation ? ST_LOAD : ST_RATE;
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_WAIT: begin
					if (cmd.commit) begin
						if (last_step) begin
							state_q <= S_OUT;
						end else begin
							step_q  <= step_t'(step_q + 4'd1);
							state_q <= S_EXEC;
						end
					end else if (state_q == S_EXEC) begin
						state_q <= S_WAIT;
					end
				end
				S_OUT: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/angle_kalman_filter.sv @@
// two-state angle and gyro bias kalman filter, top level
// An update request, from acceptance until the next request can be taken, runs ten products
// on a shared 48x16-bit multiplier, two gain divisions on a one-bit-per-cycle divider, the
// rate step, the output load and the acceptance; a load-angle request runs the acceptance,
// the angle load and the output load only. A new request is taken once the previous result
// sits in the output register, even if it is not yet collected.
// Angles and rates are signed Q16.16, noise registers unsigned Q2.30, and all sums and
// products saturate.
module angle_kalman_filter import akf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [ANGLE_W-1:0]        cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic signed [ANGLE_W-1:0] measured_angle,
	input  logic signed [ANGLE_W-1:0] measured_rate,
	input  logic [DT_W-1:0]           time_step,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ANGLE_W-1:0] filtered_angle,
	output logic signed [ANGLE_W-1:0] corrected_rate
);

	cmd_t cmd;
	sts_t sts;

	akf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	akf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measured_angle (measured_angle),
		.measured_rate  (measured_rate),
		.time_step      (time_step),
		.filtered_angle (filtered_angle),
		.corrected_rate (corrected_rate)
	);

endmodule

@@ tb/angle_kalman_filter_test.sv @@
// self-checking testbench for the angle kalman filter with a bit-exact fixed-point predictor
module angle_kalman_filter_test;
	import akf_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		logic signed [ANGLE_W-1:0] rate;
	} filter_out_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [IDX_W-1:0]          cfg_index;
	logic [ANGLE_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      operation;
	logic signed [ANGLE_W-1:0] measured_angle;
	logic signed [ANGLE_W-1:0] measured_rate;
	logic [DT_W-1:0]           time_step;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [ANGLE_W-1:0] filtered_angle;
	logic signed [ANGLE_W-1:0] corrected_rate;

	filter_out_t expected_q[$];

	longint q_angle, q_bias, r_meas;
	longint est_angle, est_bias, est_rate;
	longint cov[4];

	int  mismatches;
	int  results_seen;
	int  requests_sent;
	int  updates_sent;
	int  stall_cycles;
	bit  no_idle;
	bit  in_fire, out_fire;

	angle_kalman_filter u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// rounded scaled product, ties away from zero
	function automatic longint scaled_product(longint a, longint b, int s, int w);
		bit neg;
		logic [127:0] ua, ub, prod, lim;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		prod = ((ua * ub) + (128'd1 << (s - 1))) >> s;
		lim = (128'd1 << (w - 1)) - (neg ? 128'd0 : 128'd1);
		if (prod > lim) prod = lim;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic longint gain_quotient(longint p, longint d);
		bit neg;
		logic [127:0] up, ud, q, lim;
		neg = (p < 0) != (d < 0);
		up = (p < 0) ? 128'(-p) : 128'(p);
		ud = (d < 0) ? 128'(-d) : 128'(d);
		q = (up << 30) / ud;
		lim = (128'd1 << 47) - (neg ? 128'd0 : 128'd1);
		if (q > lim) q = lim;
		return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	function automatic void reset_filter_state();
		q_angle = Q_ANGLE_RST;
		q_bias = Q_BIAS_RST;
		r_meas = R_MEAS_RST;
		est_angle = 0;
		est_bias = 0;
		est_rate = 0;
		foreach (cov[i]) cov[i] = 0;
	endfunction

	function automatic void advance_filter(logic op, logic signed [31:0] z_in,
			logic signed [31:0] w_in, logic [19:0] dt_in);
		longint z, dt, dtp11, inner, s, k0, k1, y, p00t, p01t;
		filter_out_t r;
		z = z_in;
		dt = dt_in;
		if (op == OP_LOAD) begin
			est_angle = z;
		end else begin
			est_rate = clamp(longint'(w_in) - est_bias, 32);
			est_angle = clamp(est_angle + scaled_product(dt, est_rate, 20, 32), 32);
			dtp11 = scaled_product(dt, cov[3], 20, 48);
			inner = clamp(dtp11 - cov[1] - cov[2] + q_angle, 48);
			cov[0] = clamp(cov[0] + scaled_product(dt, inner, 20, 48), 48);
			cov[1] = clamp(cov[1] - dtp11, 48);
			cov[2] = clamp(cov[2] - dtp11, 48);
			cov[3] = clamp(cov[3] + scaled_product(q_bias, dt, 20, 48), 48);
			p00t = cov[0];
			p01t = cov[1];
			s = clamp(cov[0] + r_meas, 48);
			if (s == 0) begin
				k0 = 0;
				k1 = 0;
			end else begin
				k0 = gain_quotient(cov[0], s);
				k1 = gain_quotient(cov[2], s);
			end
			y = z - est_angle;
			est_angle = clamp(est_angle + scaled_product(k0, y, 30, 48), 32);
			est_bias = clamp(est_bias + scaled_product(k1, y, 30, 48), 32);
			cov[0] = clamp(cov[0] - scaled_product(k0, p00t, 30, 48), 48);
			cov[1] = clamp(cov[1] - scaled_product(k0, p01t, 30, 48), 48);
			cov[2] = clamp(cov[2] - scaled_product(k1, p00t, 30, 48), 48);
			cov[3] = clamp(cov[3] - scaled_product(k1, p01t, 30, 48), 48);
		end
		r.angle = est_angle[31:0];
		r.rate = est_rate[31:0];
		expected_q.push_back(r);
	endfunction

	task automatic send_request(logic op, logic [31:0] z, logic [31:0] w, logic [19:0] dt);
		if (!no_idle && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		measured_angle <= z;
		measured_rate <= w;
		time_step <= dt;
		do @(negedge clk); while (!in_ready);
		advance_filter(op, z, w, dt);
		requests_sent++;
		if (op == OP_UPDATE) updates_sent++;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_Q_ANGLE) q_angle = val;
		else if (idx == REG_Q_BIAS) q_bias = val;
		else if (idx == REG_R_MEAS) r_meas = val;
	endtask

	task automatic set_noise(logic [31:0] qa, logic [31:0] qb, logic [31:0] rm);
		wait_idle();
		write_reg(REG_Q_ANGLE, qa);
		write_reg(REG_Q_BIAS, qb);
		write_reg(REG_R_MEAS, rm);
	endtask

	// all-zero noise right after reset gives zero innovation variance
	task automatic test_zero_innovation();
		set_noise(32'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 32'sd655360, 32'sd65536, 20'd1048);
		send_request(OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 20'hfffff);
		send_request(OP_LOAD, 32'h7fff_ffff, 32'h8000_0000, 20'hfffff);
	endtask

	task automatic test_field_extremes();
		set_noise(Q_ANGLE_RST, Q_BIAS_RST, R_MEAS_RST);
		write_reg(REG_UNUSED, 32'hffff_ffff);
		send_request(OP_LOAD, 32'h8000_0000, 32'd0, 20'd0);
		send_request(OP_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 20'hfffff);
		send_request(OP_UPDATE, 32'h8000_0000, 32'h8000_0000, 20'hfffff);
		send_request(OP_UPDATE, 32'd0, 32'd0, 20'd0);
		send_request(OP_UPDATE, 32'hffff_ffff, 32'hffff_ffff, 20'd1);
		send_request(OP_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 20'hfffff);
		send_request(OP_UPDATE, 32'sd1966080, 32'sd65536, 20'd1048);
		send_request(OP_UPDATE, 32'sd1966080, -32'sd65536, 20'd10486);
	endtask

	task automatic test_noise_extremes();
		set_noise(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		repeat (4) send_request(OP_UPDATE, $urandom, $urandom, DT_W'($urandom));
		set_noise(32'hffff_ffff, 32'hffff_ffff, 32'd0);
		repeat (4) send_request(OP_UPDATE, $urandom, $urandom, 20'hfffff);
		set_noise(32'd0, 32'd0, 32'hffff_ffff);
		repeat (3) send_request(OP_UPDATE, $urandom, $urandom, DT_W'($urandom));
	endtask

	task automatic test_random_tracking(int total);
		int n;
		logic [31:0] z, w;
		logic [19:0] dt;
		n = 0;
		while (n < total) begin
			if (n % 200 == 0) begin
				case ($urandom_range(3))
					0: set_noise(Q_ANGLE_RST, Q_BIAS_RST, R_MEAS_RST);
					1: set_noise($urandom, $urandom, $urandom);
					2: set_noise($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24),
						$urandom_range(0, 1 << 28));
					default: set_noise(32'd0, $urandom, $urandom_range(0, 15));
				endcase
				no_idle = (n / 200) == 3;
			end
			if ($urandom_range(99) < 85) begin
				z = $signed($urandom_range(0, 180 << 17)) - (180 << 16);
				w = $signed($urandom_range(0, 500 << 17)) - (500 << 16);
				dt = DT_W'($urandom_range(0, 20000));
			end else begin
				z = $urandom;
				w = $urandom;
				dt = DT_W'($urandom);
			end
			send_request(($urandom_range(99) < 8) ? OP_LOAD : OP_UPDATE, z, w, dt);
			n++;
		end
		no_idle = 1'b0;
	endtask

	always @(posedge clk) begin
		if (no_idle) out_ready <= 1'b1;
		else out_ready <= $urandom_range(99) >= 6;
	end

	always @(negedge clk) begin
		in_fire <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result angle=%0d rate=%0d",
						filtered_angle, corrected_rate);
			end else begin
				filter_out_t e;
				e = expected_q.pop_front();
				if (e.angle !== filtered_angle || e.rate !== corrected_rate) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d: angle exp %0d got %0d, rate exp %0d got %0d",
							results_seen, e.angle, filtered_angle, e.rate, corrected_rate);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (in_fire || out_fire || (expected_q.size() == 0 && !in_valid)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_UPDATE;
		measured_angle = '0;
		measured_rate = '0;
		time_step = '0;
		out_ready = 1'b0;
		mismatches = 0;
		results_seen = 0;
		requests_sent = 0;
		updates_sent = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		reset_filter_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_innovation();
		test_field_extremes();
		test_noise_extremes();
		test_random_tracking(1400);
		wait_idle();
		repeat (300) @(posedge clk);
		$display("%0d requests (%0d filter updates) checked against %0d results",
			requests_sent, updates_sent, results_seen);
		$display("noise settings swept across zero, reset values, random and full scale");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/akf_pkg.sv
rtl/core/akf_mul.sv
rtl/core/akf_div.sv
rtl/core/akf_datapath.sv
rtl/core/akf_ctrl.sv
rtl/core/angle_kalman_filter.sv
tb/angle_kalman_filter_test.sv
